// ===== rtl/srrt_pkg.sv =====
// Shared types and constants for the scan result rank table.
// No dependencies; imported by every module of the block except srrt_ram.
`default_nettype none

package srrt_pkg;

    localparam int NAME_W       = 256;
    localparam int NAME_MAX_B   = 32;
    localparam int ENTRY_W      = 296;
    localparam int IN_DATA_W    = 296;
    localparam int OUT_DATA_W   = 312;
    localparam int RANK_W       = 6;
    localparam int TOTAL_W      = 7;
    localparam int OUT_PAD_W    = OUT_DATA_W - ENTRY_W - RANK_W - TOTAL_W;

    // Item kinds carried on the input tuser.
    localparam logic [1:0] KIND_START    = 2'd0;
    localparam logic [1:0] KIND_REPORT   = 2'd1;
    localparam logic [1:0] KIND_COMPLETE = 2'd2;

    localparam logic [7:0] PRINT_LOW  = 8'h20;
    localparam logic [7:0] PRINT_HIGH = 8'h7E;

    // "<hidden>", first character in the low byte.
    localparam logic [63:0] HIDDEN_TEXT = 64'h3E6E_6564_6469_683C;

    typedef struct packed {
        logic [31:0]       security;
        logic [7:0]        strength;
        logic [NAME_W-1:0] name;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic clr_cnt;
        logic ld_pos;
        logic rd_ins;
        logic shift;
        logic wr_new;
        logic ld_k;
        logic rd_emit;
        logic ld_out;
        logic ld_empty;
    } srrt_cmd_t;

    typedef struct packed {
        logic name_ok;
        logic full;
        logic pos_zero;
        logic less;
        logic cnt_zero;
        logic k_last;
        logic out_free;
    } srrt_stat_t;

endpackage

`default_nettype wire

// ===== rtl/scan_result_rank_table_core.sv =====
// Scan result rank table: keeps a sorted table of scan reports, emits it ranked.
// Start clears the count. Report: a valid name goes in below every equal or stronger
// entry, weaker ones move up one place; dropped when full. Complete: emits each entry
// while the output is taken (registered RAM read); an empty table gives one marker.
// Reset (rst_n, async low) clears the FSM, counters and output valid; the table RAM
// is not cleared, only entries below the kept count are ever read.
`default_nettype none

module scan_result_rank_table_core
    import srrt_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int NAME_BYTES  = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Input stream, one transfer per item.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata: name_word0[63:0], name_word1[127:64], name_word2[191:128],
    //        name_word3[255:192], strength[263:256], security_code[295:264]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: kind[1:0]
    input  wire logic [1:0]            s_axis_tuser,
    // Result stream, one transfer per ranked entry or empty marker.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata: out_name0[63:0], out_name1[127:64], out_name2[191:128],
    //        out_name3[255:192], out_strength[263:256], out_security[295:264],
    //        rank[301:296], entry_total[308:302], zero pad[311:309]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // tuser: table_empty[0]
    output logic                       m_axis_tuser,
    // tlast: last_entry
    output logic                       m_axis_tlast
);

    srrt_cmd_t  cmd;
    srrt_stat_t stat;

    // Controller: one item in flight; ready only while idle.
    srrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: name screening, sorted entry RAM and the result register.
    srrt_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .NAME_BYTES  (NAME_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_empty (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/srrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module srrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/srrt_ctrl.sv =====
// Sequencing FSM of the rank table: accepts items, steps insertion and emission.
// Depends on srrt_pkg; drives the datapath through srrt_cmd_t.
`default_nettype none

module srrt_ctrl
    import srrt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] in_kind,
    output logic            in_ready,
    input  wire srrt_stat_t stat,
    output srrt_cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_INS_CHK = 3'd1;
    localparam logic [2:0] ST_INS_CMP = 3'd2;
    localparam logic [2:0] ST_EMIT_RD = 3'd3;
    localparam logic [2:0] ST_EMIT_LD = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       acc;

    assign in_ready = (state_reg == ST_IDLE);
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    cmd.capture = 1'b1;
                    unique case (in_kind)
                        KIND_START:
                        begin
                            cmd.clr_cnt = 1'b1;
                        end
                        KIND_REPORT:
                        begin
                            cmd.ld_pos = 1'b1;
                            state_next = ST_INS_CHK;
                        end
                        KIND_COMPLETE:
                        begin
                            cmd.ld_k   = 1'b1;
                            state_next = ST_EMIT_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_INS_CHK:
            begin
                if (!stat.name_ok || stat.full)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.pos_zero)
                begin
                    cmd.wr_new = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.rd_ins = 1'b1;
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                if (stat.less)
                begin
                    cmd.shift  = 1'b1;
                    state_next = ST_INS_CHK;
                end
                else
                begin
                    cmd.wr_new = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_RD:
            begin
                if (stat.cnt_zero)
                begin
                    if (stat.out_free)
                    begin
                        cmd.ld_empty = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_emit = 1'b1;
                    state_next  = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD:
            begin
                if (stat.out_free)
                begin
                    cmd.ld_out = 1'b1;
                    state_next = stat.k_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/srrt_dp.sv =====
// Datapath of the rank table: name check, entry RAM, counters, output register.
// Depends on srrt_pkg and srrt_ram; steered by srrt_ctrl via srrt_cmd_t.
`default_nettype none

module srrt_dp
    import srrt_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int NAME_BYTES  = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [IN_DATA_W-1:0]  in_data,
    input  wire srrt_cmd_t             cmd,
    output srrt_stat_t                 stat,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [OUT_DATA_W-1:0]      out_data,
    output logic                       out_empty,
    output logic                       out_last
);

    localparam int AW        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW        = $clog2(MAX_ENTRIES + 1);
    localparam int HID_BYTES = (NAME_BYTES < 8) ? NAME_BYTES : 8;
    localparam logic [63:0] HIDDEN_MASK =
        (HID_BYTES == 8) ? {64{1'b1}} : ((64'd1 << (8 * HID_BYTES)) - 64'd1);

    entry_t            in_entry;
    entry_t            new_reg;
    logic              ok_reg;
    logic [NAME_W-1:0] clean;
    logic              bad;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     pos_reg;
    logic [CW-1:0]     pos_dec;
    logic [CW-1:0]     k_reg;
    logic [CW-1:0]     k_inc;
    entry_t            rd_entry;
    entry_t            wr_entry;
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic              out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic              out_empty_reg;
    logic              out_last_reg;

    assign in_entry = entry_t'(in_data);

    // Keep bytes up to the first zero; flag any kept byte outside printable ASCII.
    always_comb
    begin
        logic       run;
        logic       keep;
        logic [7:0] b;
        run   = 1'b1;
        bad   = 1'b0;
        clean = '0;
        for (int i = 0; i < NAME_MAX_B; i++)
        begin
            b    = in_entry.name[8*i +: 8];
            keep = run && (i < NAME_BYTES) && (b != 8'h00);
            if (keep && ((b < PRINT_LOW) || (b > PRINT_HIGH)))
            begin
                bad = 1'b1;
            end
            if (keep)
            begin
                clean[8*i +: 8] = b;
            end
            run = keep;
        end
        if (clean[7:0] == 8'h00)
        begin
            clean = {{(NAME_W-64){1'b0}}, HIDDEN_TEXT & HIDDEN_MASK};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            new_reg.name     <= clean;
            new_reg.strength <= in_entry.strength;
            new_reg.security <= in_entry.security;
            ok_reg           <= !bad;
        end
    end

    assign pos_dec = pos_reg - CW'(1);
    assign k_inc   = k_reg + CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            if (cmd.clr_cnt)
            begin
                count_reg <= '0;
            end
            else if (cmd.wr_new)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.ld_pos)
            begin
                pos_reg <= count_reg;
            end
            else if (cmd.shift)
            begin
                pos_reg <= pos_dec;
            end
            if (cmd.ld_k)
            begin
                k_reg <= '0;
            end
            else if (cmd.ld_out)
            begin
                k_reg <= k_inc;
            end
        end
    end

    // Entry table; insertion moves one entry up per read/write pair.
    assign ram_we    = cmd.shift || cmd.wr_new;
    assign ram_re    = cmd.rd_ins || cmd.rd_emit;
    assign ram_raddr = cmd.rd_ins ? pos_dec[AW-1:0] : k_reg[AW-1:0];
    assign wr_entry  = cmd.shift ? rd_entry : new_reg;

    srrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg[AW-1:0]),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_entry)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.ld_out || cmd.ld_empty)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_out)
        begin
            out_data_reg  <= {{OUT_PAD_W{1'b0}}, TOTAL_W'(count_reg), RANK_W'(k_reg),
                              rd_entry};
            out_empty_reg <= 1'b0;
            out_last_reg  <= stat.k_last;
        end
        else if (cmd.ld_empty)
        begin
            out_data_reg  <= '0;
            out_empty_reg <= 1'b1;
            out_last_reg  <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_empty = out_empty_reg;
    assign out_last  = out_last_reg;

    assign stat.name_ok  = ok_reg;
    assign stat.full     = (count_reg == CW'(MAX_ENTRIES));
    assign stat.pos_zero = (pos_reg == '0);
    assign stat.less     = $signed(rd_entry.strength) < $signed(new_reg.strength);
    assign stat.cnt_zero = (count_reg == '0);
    assign stat.k_last   = (k_inc == count_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

// ===== rtl/srrt_chk.sv =====
// Port-level checks for scan_result_rank_table_core, attached by bind.
// Depends on srrt_pkg.
`default_nettype none

module srrt_chk
    import srrt_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic [1:0]            s_axis_tuser,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                  m_axis_tuser,
    input wire logic                  m_axis_tlast
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Empty marker is a lone, all-zero, last transfer.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("malformed empty marker");

    // Ranked entries lie inside the reported total.
    a_rank: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            ({1'b0, m_axis_tdata[301:296]} < m_axis_tdata[308:302]))
        else $error("rank outside entry total");

    // The flagged last entry carries the final rank.
    a_last_rank: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser && m_axis_tlast |->
            ({1'b0, m_axis_tdata[301:296]} + 7'd1 == m_axis_tdata[308:302]))
        else $error("last entry rank mismatch");

    // After a start item the block is ready again in the next cycle.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_START) |=> s_axis_tready)
        else $error("not ready after start");

endmodule

bind scan_result_rank_table_core srrt_chk u_srrt_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== bench/scan_result_rank_table_core_tb.sv =====
// Self-checking bench for scan_result_rank_table_core: directed table, then random scans.
// Depends on srrt_pkg and the core; expected rankings come from a local table predictor.
`timescale 1ns / 100ps

module scan_result_rank_table_core_tb;
    import srrt_pkg::*;

    localparam int          TABLE_DEPTH    = 16;
    localparam int          RANDOM_ITEMS   = 90;
    localparam int          SETTLE_CYCLES  = 80;
    localparam logic [1:0]  KIND_UNUSED    = 2'd3;

    // One input item, fields as they travel on the input stream.
    typedef struct packed {
        logic [1:0]   kind;
        logic [255:0] name;
        logic [7:0]   strength;
        logic [31:0]  security;
    } scan_item_t;

    // One ranked entry or empty marker as seen on the result stream.
    typedef struct packed {
        logic [255:0] name;
        logic [7:0]   strength;
        logic [31:0]  security;
        logic [5:0]   rank;
        logic [6:0]   total;
        logic         empty;
        logic         last;
    } ranked_t;

    typedef struct {
        scan_item_t item;
        bit         typed;
        ranked_t    want;
        bit         drain;
    } stim_row_t;

    localparam ranked_t EMPTY_MARKER = '{name: '0, strength: '0, security: '0, rank: '0,
                                         total: '0, empty: 1'b1, last: 1'b1};

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = KIND_START;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    // Predictor state: the ranked table as the block should hold it.
    logic [255:0]       held_name     [TABLE_DEPTH];
    logic signed [7:0]  held_strength [TABLE_DEPTH];
    logic [31:0]        held_security [TABLE_DEPTH];
    int unsigned        held_count = 0;

    ranked_t   ranked_due[$];
    stim_row_t directed_table[$];
    int        fail_count  = 0;
    int        random_sent = 0;
    bit        calm        = 1'b0;  // no idling on either side while set

    scan_result_rank_table_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #1ms;
        $display("== FAIL ==");
        $finish;
    end

    // Text to name words, first character in the low byte, zero padded.
    function automatic logic [255:0] text_name(input string s);
        logic [255:0] w;
        w = '0;
        for (int i = 0; i < s.len() && i < NAME_MAX_B; i++)
            w[i*8 +: 8] = s[i];
        return w;
    endfunction

    // Name check and stable insert: the new entry goes after every entry of
    // equal or greater strength. Dropped when full or a byte is not printable.
    task automatic rank_in_report(input scan_item_t it);
        logic [255:0]      kept;
        logic [7:0]        b;
        int unsigned       len;
        int unsigned       pos;
        logic signed [7:0] sv;
        kept = '0;
        len  = 0;
        if (held_count >= TABLE_DEPTH)
            return;
        while (len < NAME_MAX_B && it.name[len*8 +: 8] != 8'h00)
        begin
            b = it.name[len*8 +: 8];
            if (b < PRINT_LOW || b > PRINT_HIGH)
                return;
            kept[len*8 +: 8] = b;
            len++;
        end
        if (len == 0)
            kept[63:0] = HIDDEN_TEXT;
        sv  = $signed(it.strength);
        pos = held_count;
        while (pos > 0 && held_strength[pos-1] < sv)
        begin
            held_name[pos]     = held_name[pos-1];
            held_strength[pos] = held_strength[pos-1];
            held_security[pos] = held_security[pos-1];
            pos--;
        end
        held_name[pos]     = kept;
        held_strength[pos] = sv;
        held_security[pos] = it.security;
        held_count++;
    endtask

    task automatic emit_ranking();
        ranked_t r;
        if (held_count == 0)
        begin
            ranked_due.push_back(EMPTY_MARKER);
            return;
        end
        for (int unsigned k = 0; k < held_count; k++)
        begin
            r.name     = held_name[k];
            r.strength = held_strength[k];
            r.security = held_security[k];
            r.rank     = k[5:0];
            r.total    = held_count[6:0];
            r.empty    = 1'b0;
            r.last     = (k + 1 == held_count);
            ranked_due.push_back(r);
        end
    endtask

    // Drive one item and hold it until the transfer; valid stays high for the
    // next item unless an idle cycle is drawn.
    task automatic send_item(input scan_item_t it, input bit typed = 1'b0,
                             input ranked_t want = '0);
        while (!calm && $urandom_range(0, 99) < 37)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= {it.security, it.strength, it.name};
        do
            @(posedge clk);
        while (!s_axis_tready);
        case (it.kind)
            KIND_START:    held_count = 0;
            KIND_REPORT:   rank_in_report(it);
            KIND_COMPLETE:
            begin
                if (typed)
                    ranked_due.push_back(want);
                else
                    emit_ranking();
            end
            default: ;
        endcase
    endtask

    // Sender holds off until every outstanding result has been taken.
    task automatic drain_results();
        if (ranked_due.size() != 0)
        begin
            s_axis_tvalid <= 1'b0;
            while (ranked_due.size() != 0)
                @(posedge clk);
        end
    endtask

    function automatic scan_item_t random_report();
        scan_item_t  it;
        int unsigned len;
        int unsigned bad;
        it.kind     = KIND_REPORT;
        it.name     = '0;
        len         = $urandom_range(0, NAME_MAX_B);
        for (int i = 0; i < NAME_MAX_B; i++)
        begin
            if (i < len)
                it.name[i*8 +: 8] = 8'($urandom_range(PRINT_LOW, PRINT_HIGH));
            else if (i > len && $urandom_range(0, 1) == 1)
                it.name[i*8 +: 8] = 8'($urandom_range(0, 255));   // junk past the terminator
        end
        // occasionally poison one byte at or before the terminator
        if ($urandom_range(0, 99) < 8)
        begin
            bad = $urandom_range(0, (len < NAME_MAX_B) ? len : NAME_MAX_B - 1);
            it.name[bad*8 +: 8] = ($urandom_range(0, 1) == 1) ?
                8'($urandom_range(1, 8'h1F)) : 8'($urandom_range(8'h7F, 8'hFF));
        end
        // narrow strengths make ties common
        if ($urandom_range(0, 99) < 30)
            it.strength = 8'($signed($urandom_range(0, 6)) - 3);
        else
            it.strength = 8'($urandom_range(0, 255));
        it.security = $urandom;
        return it;
    endfunction

    task automatic add_row(input logic [1:0] kind, input logic [255:0] name = '0,
                           input logic [7:0] strength = '0, input logic [31:0] security = '0,
                           input bit typed = 1'b0, input ranked_t want = '0,
                           input bit drain = 1'b0);
        stim_row_t row;
        row.item  = '{kind: kind, name: name, strength: strength, security: security};
        row.typed = typed;
        row.want  = want;
        row.drain = drain;
        directed_table.push_back(row);
    endtask

    // Result side: random backpressure, every transfer checked in order.
    always @(posedge clk)
    begin
        ranked_t got;
        ranked_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.name     = m_axis_tdata[255:0];
                got.strength = m_axis_tdata[263:256];
                got.security = m_axis_tdata[295:264];
                got.rank     = m_axis_tdata[301:296];
                got.total    = m_axis_tdata[308:302];
                got.empty    = m_axis_tuser;
                got.last     = m_axis_tlast;
                if (ranked_due.size() == 0)
                begin
                    $error("result transfer with nothing expected: %h", got);
                    fail_count++;
                end
                else
                begin
                    want = ranked_due.pop_front();
                    for (int w = 0; w < 4; w++)
                        if (got.name[w*64 +: 64] !== want.name[w*64 +: 64])
                        begin
                            $error("out_name%0d mismatch: expected %h, got %h", w,
                                   want.name[w*64 +: 64], got.name[w*64 +: 64]);
                            fail_count++;
                        end
                    if (got.strength !== want.strength)
                    begin
                        $error("out_strength mismatch: expected %h, got %h",
                               want.strength, got.strength);
                        fail_count++;
                    end
                    if (got.security !== want.security)
                    begin
                        $error("out_security mismatch: expected %h, got %h",
                               want.security, got.security);
                        fail_count++;
                    end
                    if (got.rank !== want.rank)
                    begin
                        $error("rank mismatch: expected %0d, got %0d", want.rank, got.rank);
                        fail_count++;
                    end
                    if (got.total !== want.total)
                    begin
                        $error("entry_total mismatch: expected %0d, got %0d",
                               want.total, got.total);
                        fail_count++;
                    end
                    if (got.empty !== want.empty)
                    begin
                        $error("table_empty mismatch: expected %b, got %b",
                               want.empty, got.empty);
                        fail_count++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last_entry mismatch: expected %b, got %b",
                               want.last, got.last);
                        fail_count++;
                    end
                end
            end
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 37);
        end
    end

    initial
    begin
        scan_item_t  it;
        int unsigned n;
        logic [255:0] nm;

        // Directed rows. Typed results only where they are obvious.
        add_row(KIND_COMPLETE, '0, '0, '0, 1'b1, EMPTY_MARKER);   // nothing kept after reset
        add_row(KIND_UNUSED, '1, 8'hFF, 32'hFFFF_FFFF);            // ignored kind
        add_row(KIND_REPORT, '0, 8'h80, 32'hFFFF_FFFF);            // empty name, weakest
        add_row(KIND_COMPLETE, '0, '0, '0, 1'b1,
                '{name: {192'd0, HIDDEN_TEXT}, strength: 8'h80, security: 32'hFFFF_FFFF,
                  rank: 6'd0, total: 7'd1, empty: 1'b0, last: 1'b1});
        add_row(KIND_START);
        add_row(KIND_REPORT, {NAME_MAX_B{8'h7E}}, 8'h7F, 32'h0);   // full-length name, strongest
        add_row(KIND_REPORT, {{30{8'hFF}}, 8'h00, 8'h20}, 8'h7F,   // tie; junk after terminator
                32'h1234_5678);
        nm = text_name("ab");
        nm[23:16] = 8'h1F;
        add_row(KIND_REPORT, nm, 8'h10, 32'h1);                    // control char, dropped
        nm = text_name("guest_net");
        nm[47:40] = 8'h7F;
        add_row(KIND_REPORT, nm, 8'h10, 32'h2);                    // DEL, dropped
        nm = {NAME_MAX_B{8'h59}};
        nm[255:248] = 8'h80;
        add_row(KIND_REPORT, nm, 8'h10, 32'h3);                    // high bit in last byte, dropped
        add_row(KIND_REPORT, text_name("mid"), 8'h00, 32'hA5A5_A5A5);
        add_row(KIND_REPORT, text_name("weak"), 8'h81, 32'h5A5A_5A5A);
        add_row(KIND_COMPLETE, '0, '0, '0, 1'b0, '0, 1'b1);
        add_row(KIND_COMPLETE);                                    // repeated complete
        add_row(KIND_REPORT, text_name("late"), 8'h05, 32'hDEAD_BEEF);
        add_row(KIND_COMPLETE);
        add_row(KIND_START);
        add_row(KIND_START);
        add_row(KIND_COMPLETE, '0, '0, '0, 1'b1, EMPTY_MARKER);
        add_row(KIND_UNUSED);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_table[i])
        begin
            send_item(directed_table[i].item, directed_table[i].typed, directed_table[i].want);
            if (directed_table[i].drain)
                drain_results();
        end

        // Random part: mostly whole scans with random content, some noise.
        // The first scan overfills the table.
        n = 20;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (random_sent > 0 && $urandom_range(0, 99) < 15)
            begin
                it.kind     = 2'($urandom);
                it.name     = {$urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom};
                it.strength = 8'($urandom);
                it.security = $urandom;
                send_item(it);
                if (it.kind != KIND_UNUSED)
                    random_sent++;
            end
            else
            begin
                it      = '0;
                it.kind = KIND_START;
                send_item(it);
                repeat (n)
                    send_item(random_report());
                it.kind = KIND_COMPLETE;
                send_item(it);
                random_sent += n + 2;
                if ($urandom_range(0, 99) < 20)
                begin
                    n = $urandom_range(1, 3);
                    repeat (n)
                        send_item(random_report());
                    send_item(it);
                    random_sent += n + 1;
                end
                if ($urandom_range(0, 99) < 25)
                    drain_results();
                n = ($urandom_range(0, 99) < 15) ? $urandom_range(13, 22) : $urandom_range(0, 10);
            end
            calm = (random_sent >= 30 && random_sent < 60);
        end
        calm = 1'b0;

        drain_results();
        s_axis_tvalid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && ranked_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
